// ===== design/itt_pkg.sv =====
// ----------------------------------------------------------------------------
// itt_pkg: shared types and constants of the interval timer table
// item layouts, opcodes, status codes, register indexes and sequencer states
// ----------------------------------------------------------------------------
package itt_pkg;

	localparam int SLOTS_DEF  = 16;
	localparam int OP_W       = 2;
	localparam int SLOT_W     = 4;
	localparam int TIME_W     = 32;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	// reset values of the configuration registers and the shortest interval
	localparam logic [TIME_W-1:0] MAX_POLL_RST    = TIME_W'(1000);
	localparam logic [TIME_W-1:0] DEFAULT_IVL_RST = TIME_W'(1000);

	// opcodes
	localparam logic [OP_W-1:0] OP_POLL  = 2'd0;
	localparam logic [OP_W-1:0] OP_REG   = 2'd1;
	localparam logic [OP_W-1:0] OP_UNREG = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ALREADY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_REG = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_POLL    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_IVL = 1'd1;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [SLOT_W-1:0] slot;
		logic [TIME_W-1:0] interval;
		logic [TIME_W-1:0] tick_ms;
	} req_t;

	typedef struct packed {
		logic                fired;
		logic [SLOT_W-1:0]   fired_slot;
		logic [TIME_W-1:0]   poll_interval;
		logic [STATUS_W-1:0] status;
		logic                last;
	} rsp_t;

	// operands of the slot arithmetic unit
	typedef struct packed {
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] due;
		logic [TIME_W-1:0] ivl;
		logic [TIME_W-1:0] bound;
	} unit_in_t;

	// results of the slot arithmetic unit
	typedef struct packed {
		logic [TIME_W-1:0] sum;
		logic              sum_zero;
		logic [TIME_W-1:0] next_due;
		logic              late;
		logic [TIME_W-1:0] lead;
		logic              lead_lt;
		logic              ivl_lt;
	} unit_out_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_UNREG,
		S_POLL,
		S_FIN
	} st_t;

endpackage

// ===== design/itt_req_if.sv =====
// ----------------------------------------------------------------------------
// itt_req_if: input channel of the interval timer table
// valid/ready handshake carrying one request item
// ----------------------------------------------------------------------------
interface itt_req_if;
	logic          valid;
	logic          ready;
	itt_pkg::req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== design/itt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// itt_rsp_if: output channel of the interval timer table
// valid/ready handshake carrying one result item
// ----------------------------------------------------------------------------
interface itt_rsp_if;
	logic          valid;
	logic          ready;
	itt_pkg::rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== design/interval_timer_table.sv =====
// ----------------------------------------------------------------------------
// interval_timer_table: table of periodic timer slots
// register, unregister and poll items over SLOTS armed timer slots
// ----------------------------------------------------------------------------
// The block takes one item at a time. A register item (and any item that is
// rejected or ignored) answers with its single result item in the cycle after
// it is accepted. An unregister item walks every slot to find the new shortest
// interval. A poll item walks the slots in slot order, one per cycle through
// the shared slot arithmetic unit while no fired item waits on the output,
// and gives a fired item for each due slot followed by a final item carrying
// the poll interval, which waits in turn until the output register is free.
// The pace of the walk is set by the single read port of the due time and
// interval memories, which the walk reads one slot at a time. Items are taken
// only when the output register is free or being emptied. Configuration
// writes are taken at any time but are meant for idle periods. Due times and
// intervals live in RAM without reset; a flop per slot marks the armed slots,
// so there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module interval_timer_table #(
	parameter int SLOTS = itt_pkg::SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [itt_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [itt_pkg::CFG_DATA_W-1:0]   cfg_data,
	itt_req_if.sink                          req,
	itt_rsp_if.source                        rsp
);
	import itt_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;  // slot address
	localparam int CW = $clog2(SLOTS + 1);                 // walk counter, holds SLOTS

	// sequencer and walk state
	st_t              state_q, state_d;
	logic [CW-1:0]    idx_q, idx_d;          // next slot to read
	logic             pv_s1, pv_d;           // a read is in flight
	logic [IW-1:0]    idx_s1, idx_s1_d;      // slot whose data sits on the ram output
	logic [SLOTS-1:0] armed_q, armed_d;

	// working values of the current item
	logic [TIME_W-1:0] now_q, now_d;
	logic [TIME_W-1:0] poll_q, poll_d;
	logic [TIME_W-1:0] min_q, min_d;
	logic [OP_W-1:0]   op_q, op_d;

	// configuration and persistent state
	logic [TIME_W-1:0] max_poll_q, max_poll_d;
	logic [TIME_W-1:0] default_q, default_d;
	logic [TIME_W-1:0] shortest_q, shortest_d;

	// output register
	logic out_valid_q, out_valid_d;
	rsp_t out_q, out_d;
	logic out_free;

	// memory ports
	logic              rd_en;
	logic [IW-1:0]     rd_addr;
	logic [TIME_W-1:0] due_rd, ivl_rd;
	logic              due_we, ivl_we;
	logic [IW-1:0]     due_wa;
	logic [TIME_W-1:0] due_wd;

	// shared unit
	unit_in_t  ui;
	unit_out_t uo;

	// decoded item
	logic          in_range;
	logic [IW-1:0] sidx;
	logic          slot_armed;
	logic          walk_done;
	logic          fire;
	logic [TIME_W-1:0] short_pick;

	itt_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_due_ram (
		.clk (clk),
		.we  (due_we),
		.wa  (due_wa),
		.wd  (due_wd),
		.re  (rd_en),
		.ra  (rd_addr),
		.rd  (due_rd)
	);

	itt_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_ivl_ram (
		.clk (clk),
		.we  (ivl_we),
		.wa  (sidx),
		.wd  (req.payload.interval),
		.re  (rd_en),
		.ra  (rd_addr),
		.rd  (ivl_rd)
	);

	itt_unit u_unit (
		.ui (ui),
		.uo (uo)
	);

	assign out_free    = !out_valid_q || rsp.ready;
	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

	assign in_range   = (32'(req.payload.slot) < 32'(SLOTS));
	assign sidx       = IW'(req.payload.slot);
	assign slot_armed = armed_q[sidx];
	assign rd_addr    = idx_q[IW-1:0];
	assign walk_done  = !pv_s1 && (idx_q == CW'(SLOTS));
	// a slot with data on the ram output that is due now
	assign fire       = pv_s1 && armed_q[idx_s1] && uo.late;

	// unit operands: the incoming item while idle, the ram output during a walk
	always_comb begin
		if (state_q == S_IDLE) begin
			ui.now   = req.payload.tick_ms;
			ui.due   = req.payload.tick_ms;
			ui.ivl   = req.payload.interval;
			ui.bound = shortest_q;
		end else begin
			ui.now   = now_q;
			ui.due   = due_rd;
			ui.ivl   = ivl_rd;
			ui.bound = (state_q == S_POLL) ? poll_q : min_q;
		end
	end

	// new shortest interval on register: the smaller one, zero replaced by the maximum poll interval
	assign short_pick = uo.ivl_lt ? req.payload.interval : shortest_q;

	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		pv_d        = pv_s1;
		idx_s1_d    = idx_s1;
		armed_d     = armed_q;
		now_d       = now_q;
		poll_d      = poll_q;
		min_d       = min_q;
		op_d        = op_q;
		max_poll_d  = max_poll_q;
		default_d   = default_q;
		shortest_d  = shortest_q;
		out_valid_d = out_valid_q && !rsp.ready;
		out_d       = out_q;
		rd_en       = 1'b0;
		due_we      = 1'b0;
		due_wa      = sidx;
		due_wd      = uo.sum;
		ivl_we      = 1'b0;
		req.ready   = 1'b0;

		if (cfg_we) begin
			unique case (cfg_idx)
				REG_MAX_POLL:    max_poll_d = cfg_data;
				REG_DEFAULT_IVL: default_d  = cfg_data;
				default: ;
			endcase
		end

		unique case (state_q)
			S_IDLE: begin
				req.ready = out_free;
				if (req.valid && out_free) begin
					op_d  = req.payload.op;
					out_d = '{fired: 1'b0, fired_slot: '0, poll_interval: '0,
						status: ST_OK, last: 1'b1};
					out_valid_d = 1'b1;
					case (req.payload.op)
						OP_POLL: begin
							// the final item of the walk fills the output
							out_valid_d = out_valid_q && !rsp.ready;
							out_d       = out_q;
							now_d       = req.payload.tick_ms;
							poll_d      = max_poll_q;
							idx_d       = '0;
							pv_d        = 1'b0;
							state_d     = S_POLL;
						end
						OP_REG: begin
							if (in_range) begin
								if (slot_armed) begin
									out_d.status = ST_ALREADY;
								end else begin
									ivl_we = 1'b1;
									due_we = 1'b1;
									shortest_d = (short_pick == '0) ? max_poll_q : short_pick;
									// a due time that wraps to zero leaves the slot free
									armed_d[sidx] = !uo.sum_zero;
								end
							end
						end
						OP_UNREG: begin
							if (in_range) begin
								if (!slot_armed) begin
									out_d.status = ST_NOT_REG;
								end else begin
									out_valid_d   = out_valid_q && !rsp.ready;
									out_d         = out_q;
									armed_d[sidx] = 1'b0;
									min_d         = default_q;
									idx_d         = '0;
									pv_d          = 1'b0;
									state_d       = S_UNREG;
								end
							end
						end
						default: ;
					endcase
				end
			end

			S_UNREG: begin
				// minimum interval over the slots still armed
				if (pv_s1 && armed_q[idx_s1] && uo.ivl_lt) begin
					min_d = ivl_rd;
				end
				if (idx_q != CW'(SLOTS)) begin
					rd_en    = 1'b1;
					idx_d    = CW'(idx_q + 1'b1);
					pv_d     = 1'b1;
					idx_s1_d = idx_q[IW-1:0];
				end else begin
					pv_d = 1'b0;
				end
				if (walk_done) begin
					state_d = S_FIN;
				end
			end

			S_POLL: begin
				// a due slot waits here until the output register can take its item
				if (!(fire && !out_free)) begin
					if (fire) begin
						due_we      = 1'b1;
						due_wa      = idx_s1;
						due_wd      = uo.next_due;
						out_d       = '{fired: 1'b1, fired_slot: SLOT_W'(idx_s1),
							poll_interval: '0, status: ST_OK, last: 1'b0};
						out_valid_d = 1'b1;
					end else if (pv_s1 && armed_q[idx_s1] && uo.lead_lt) begin
						poll_d = uo.lead;
					end
					if (idx_q != CW'(SLOTS)) begin
						rd_en    = 1'b1;
						idx_d    = CW'(idx_q + 1'b1);
						pv_d     = 1'b1;
						idx_s1_d = idx_q[IW-1:0];
					end else begin
						pv_d = 1'b0;
					end
					if (walk_done) begin
						state_d = S_FIN;
					end
				end
			end

			S_FIN: begin
				if (out_free) begin
					out_d = '{fired: 1'b0, fired_slot: '0, poll_interval: '0,
						status: ST_OK, last: 1'b1};
					if (op_q == OP_POLL) begin
						out_d.poll_interval = (poll_q > shortest_q) ? shortest_q : poll_q;
					end else begin
						shortest_d = min_q;
					end
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end

			default: state_d = S_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			pv_s1       <= 1'b0;
			armed_q     <= '0;
			out_valid_q <= 1'b0;
			max_poll_q  <= MAX_POLL_RST;
			default_q   <= DEFAULT_IVL_RST;
			shortest_q  <= DEFAULT_IVL_RST;
		end else begin
			state_q     <= state_d;
			idx_q       <= idx_d;
			pv_s1       <= pv_d;
			armed_q     <= armed_d;
			out_valid_q <= out_valid_d;
			max_poll_q  <= max_poll_d;
			default_q   <= default_d;
			shortest_q  <= shortest_d;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		idx_s1 <= idx_s1_d;
		now_q  <= now_d;
		poll_q <= poll_d;
		min_q  <= min_d;
		op_q   <= op_d;
		out_q  <= out_d;
	end

endmodule

// ===== design/itt_ram.sv =====
// ----------------------------------------------------------------------------
// itt_ram: generic single-port-write, single-port-read RAM
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
module itt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wa,
	input  logic [WIDTH-1:0]                      wd,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] ra,
	output logic [WIDTH-1:0]                      rd
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		if (re) begin
			rd_q <= mem_q[ra];
		end
	end

	assign rd = rd_q;

endmodule

// ===== design/itt_unit.sv =====
// ----------------------------------------------------------------------------
// itt_unit: slot arithmetic unit
// due-time add, wrap-aware lateness test and the two minimum compares
// ----------------------------------------------------------------------------
module itt_unit (
	input  itt_pkg::unit_in_t  ui,
	output itt_pkg::unit_out_t uo
);
	import itt_pkg::*;

	logic [TIME_W-1:0] sum;
	logic [TIME_W-1:0] lead;

	assign sum  = ui.due + ui.ivl;
	assign lead = ui.due - ui.now;

	always_comb begin
		uo.sum      = sum;
		uo.sum_zero = (sum == '0);
		// a due time that lands on zero would read as a free slot
		uo.next_due = (sum == '0) ? TIME_W'(1) : sum;
		// now - due >= 0 as signed, from due - now: zero or strictly above half the range
		uo.late     = (lead == '0) || (lead[TIME_W-1] && (lead[TIME_W-2:0] != '0));
		uo.lead     = lead;
		uo.lead_lt  = (lead < ui.bound);
		uo.ivl_lt   = (ui.ivl < ui.bound);
	end

endmodule
